@@ src/gwm_pkg.sv @@
// shared constants and types for the glob wildcard matcher
package gwm_pkg;

   localparam int BYTE_W           = 8;
   localparam int CSR_ADDR_W       = 3;
   localparam int CSR_DATA_W       = 64;
   localparam int LEN_FIELD_W      = 6;
   localparam int PAT_BYTES_PER_REG = CSR_DATA_W / BYTE_W;
   localparam int PAT_STORE        = 32;

   localparam logic [BYTE_W-1:0] CH_STAR     = 8'h2A;
   localparam logic [BYTE_W-1:0] CH_QUESTION = 8'h3F;

   typedef enum logic [CSR_ADDR_W-1:0] {
      REG_PAT_0_7   = 3'd0,
      REG_PAT_8_15  = 3'd1,
      REG_PAT_16_23 = 3'd2,
      REG_PAT_24_31 = 3'd3,
      REG_PAT_LEN   = 3'd4
   } csr_reg_type;

endpackage

@@ src/gwm_csr.sv @@
// pattern and length registers with star flags per pattern position
module gwm_csr
   import gwm_pkg::*;
#(
   parameter int PAT_MAX = 32,
   parameter int LEN_W   = 6
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_we,
   input  logic [CSR_ADDR_W-1:0]         csr_addr,
   input  logic [CSR_DATA_W-1:0]         csr_wdata,
   output logic [PAT_MAX-1:0][BYTE_W-1:0] pat_bytes,
   output logic [PAT_MAX-1:0]            pat_star,
   output logic [LEN_W-1:0]              pat_len
);

   logic [PAT_MAX-1:0][BYTE_W-1:0] pat_ff;
   logic [LEN_W-1:0]               len_ff;
   logic [LEN_W-1:0]               len_in;
   logic [LEN_FIELD_W-1:0]         len_raw;

   assign len_raw = csr_wdata[LEN_FIELD_W-1:0];

   // saturate to the stored pattern size
   always_comb begin
      if (len_raw > LEN_FIELD_W'(PAT_MAX)) begin
         len_in = LEN_W'(PAT_MAX);
      end else begin
         len_in = len_raw[LEN_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pat_ff <= '0;
      end else if (csr_we) begin
         for (int i = 0; i < PAT_MAX; i++) begin
            if (csr_addr == CSR_ADDR_W'(i / PAT_BYTES_PER_REG)) begin
               pat_ff[i] <= csr_wdata[(i % PAT_BYTES_PER_REG)*BYTE_W +: BYTE_W];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff <= '0;
      end else if (csr_we && (csr_addr == REG_PAT_LEN)) begin
         len_ff <= len_in;
      end
   end

   always_comb begin
      for (int i = 0; i < PAT_MAX; i++) begin
         pat_star[i] = (pat_ff[i] == CH_STAR) && (LEN_W'(i) < len_ff);
      end
   end

   assign pat_bytes = pat_ff;
   assign pat_len   = len_ff;

endmodule

@@ src/gwm_closure.sv @@
// star closure of a live position vector as a log-depth prefix network
module gwm_closure #(
   parameter int VEC_W = 33
) (
   input  logic [VEC_W-1:0] seed,
   input  logic [VEC_W-1:0] prop,
   output logic [VEC_W-1:0] closed
);

   localparam int LEVELS = $clog2(VEC_W);

   logic [VEC_W-1:0] g [LEVELS+1];
   logic [VEC_W-1:0] p [LEVELS];

   assign g[0] = seed;
   assign p[0] = prop;

   for (genvar s = 0; s < LEVELS; s++) begin : g_lvl
      localparam int DIST = 1 << s;
      for (genvar j = 0; j < VEC_W; j++) begin : g_bit
         if (j >= DIST) begin : g_far
            assign g[s+1][j] = g[s][j] | (p[s][j] & g[s][j-DIST]);
            if (s + 1 < LEVELS) begin : g_p
               assign p[s+1][j] = p[s][j] & p[s][j-DIST];
            end
         end else begin : g_near
            assign g[s+1][j] = g[s][j];
            if (s + 1 < LEVELS) begin : g_p
               assign p[s+1][j] = p[s][j];
            end
         end
      end
   end

   assign closed = g[LEVELS];

endmodule

@@ src/gwm_core.sv @@
// input register, live position update and result register
module gwm_core
   import gwm_pkg::*;
#(
   parameter int PAT_MAX = 32,
   parameter int LEN_W   = 6
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_tvalid,
   output logic                           req_tready,
   input  logic [BYTE_W-1:0]              req_byte,
   input  logic                           req_present,
   input  logic                           req_last,
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   output logic                           rsp_matched,
   input  logic [PAT_MAX-1:0][BYTE_W-1:0] pat_bytes,
   input  logic [PAT_MAX-1:0]             pat_star,
   input  logic [LEN_W-1:0]               pat_len
);

   localparam int VEC_W = PAT_MAX + 1;

   logic              in_vld_ff;
   logic [BYTE_W-1:0] byte_ff;
   logic              present_ff;
   logic              last_ff;
   logic [VEC_W-1:0]  live_ff;
   logic [VEC_W-1:0]  live_in;
   logic              out_vld_ff;
   logic              match_ff;

   logic              go;
   logic [VEC_W-1:0]  len_mask;
   logic [VEC_W-1:0]  prop;
   logic [VEC_W-1:0]  closed_live;
   logic [VEC_W-1:0]  stepped;
   logic [VEC_W-1:0]  closed_step;
   logic [VEC_W-1:0]  result_vec;
   logic [PAT_MAX-1:0] sym_hit;
   logic [PAT_MAX-1:0] live_low;

   assign go = in_vld_ff && (!last_ff || !out_vld_ff || rsp_tready);
   assign req_tready = !in_vld_ff || go;

   always_comb begin
      for (int j = 0; j < VEC_W; j++) begin
         len_mask[j] = (LEN_W'(j) <= pat_len);
      end
   end

   assign prop = {pat_star, 1'b0};

   gwm_closure #(.VEC_W(VEC_W)) u_close_live (
      .seed   (live_ff & len_mask),
      .prop   (prop),
      .closed (closed_live)
   );

   always_comb begin
      for (int i = 0; i < PAT_MAX; i++) begin
         sym_hit[i] = (LEN_W'(i) < pat_len) && (pat_bytes[i] != CH_STAR)
                      && ((pat_bytes[i] == CH_QUESTION) || (pat_bytes[i] == byte_ff));
      end
   end

   assign live_low = closed_live[PAT_MAX-1:0];
   assign stepped  = {1'b0, live_low & pat_star} | {live_low & sym_hit, 1'b0};

   gwm_closure #(.VEC_W(VEC_W)) u_close_step (
      .seed   (stepped),
      .prop   (prop),
      .closed (closed_step)
   );

   assign result_vec = present_ff ? closed_step : closed_live;

   // re-arm at the end of a name
   assign live_in = last_ff ? VEC_W'(1) : result_vec;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff <= 1'b0;
      end else if (req_tready) begin
         in_vld_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         byte_ff    <= req_byte;
         present_ff <= req_present;
         last_ff    <= req_last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         live_ff <= VEC_W'(1);
      end else if (go) begin
         live_ff <= live_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff <= 1'b0;
      end else if (go && last_ff) begin
         out_vld_ff <= 1'b1;
      end else if (rsp_tready) begin
         out_vld_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (go && last_ff) begin
         match_ff <= result_vec[pat_len];
      end
   end

   assign rsp_tvalid  = out_vld_ff;
   assign rsp_matched = match_ff;

endmodule

@@ src/glob_wildcard_matcher_top.sv @@
// a name's last transaction is held in the input register, then its match in match_ff
// throughput: one byte transaction per cycle while no finished name waits on rsp_tready
// a waiting result does not block input until a second result is ready behind it
// reset: control and live positions cleared to position zero, pattern and length to zero
// top level of the glob wildcard matcher
module glob_wildcard_matcher_top
   import gwm_pkg::*;
#(
   parameter int PATTERN_CHARS = 32
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [7:0]            req_tdata,   // text_byte
   input  logic                  req_tuser,   // byte_present
   input  logic                  req_tlast,   // end_of_name
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [7:0]            rsp_tdata,   // matched, zero fill
   input  logic                  csr_we,
   input  logic [CSR_ADDR_W-1:0] csr_addr,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   localparam int PAT_MAX = (PATTERN_CHARS < PAT_STORE) ? PATTERN_CHARS : PAT_STORE;
   localparam int LEN_W   = $clog2(PAT_MAX + 1);

   logic [PAT_MAX-1:0][BYTE_W-1:0] pat_bytes;
   logic [PAT_MAX-1:0]             pat_star;
   logic [LEN_W-1:0]               pat_len;
   logic                           matched;

   gwm_csr #(.PAT_MAX(PAT_MAX), .LEN_W(LEN_W)) u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_addr  (csr_addr),
      .csr_wdata (csr_wdata),
      .pat_bytes (pat_bytes),
      .pat_star  (pat_star),
      .pat_len   (pat_len)
   );

   gwm_core #(.PAT_MAX(PAT_MAX), .LEN_W(LEN_W)) u_core (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_byte    (req_tdata),
      .req_present (req_tuser),
      .req_last    (req_tlast),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_matched (matched),
      .pat_bytes   (pat_bytes),
      .pat_star    (pat_star),
      .pat_len     (pat_len)
   );

   assign rsp_tdata = {7'b0, matched};

endmodule
